[hdl/sgrap_pkg.sv]
// Shared types, SGR codes and field layouts for the SGR attribute processor.
`timescale 1ns / 1ps

package sgrap_pkg;

    localparam int CODE_W = 16;
    localparam int SUB_W  = 17;
    localparam int COL_W  = 25;
    localparam int FLAG_W = 9;

    // Style flag bit positions.
    localparam int FLAG_BOLD      = 0;
    localparam int FLAG_FAINT     = 1;
    localparam int FLAG_ITALIC    = 2;
    localparam int FLAG_UNDERLINE = 3;
    localparam int FLAG_BLINK     = 4;
    localparam int FLAG_REVERSE   = 5;
    localparam int FLAG_INVISIBLE = 6;
    localparam int FLAG_STRUCK    = 7;
    localparam int FLAG_DIRTY_UL  = 8;

    // SGR parameter codes.
    localparam logic [CODE_W-1:0] CODE_RESET        = 16'd0;
    localparam logic [CODE_W-1:0] CODE_BOLD         = 16'd1;
    localparam logic [CODE_W-1:0] CODE_FAINT        = 16'd2;
    localparam logic [CODE_W-1:0] CODE_ITALIC       = 16'd3;
    localparam logic [CODE_W-1:0] CODE_UNDERLINE    = 16'd4;
    localparam logic [CODE_W-1:0] CODE_BLINK_SLOW   = 16'd5;
    localparam logic [CODE_W-1:0] CODE_BLINK_FAST   = 16'd6;
    localparam logic [CODE_W-1:0] CODE_REVERSE      = 16'd7;
    localparam logic [CODE_W-1:0] CODE_INVISIBLE    = 16'd8;
    localparam logic [CODE_W-1:0] CODE_STRUCK       = 16'd9;
    localparam logic [CODE_W-1:0] CODE_NO_BOLD      = 16'd22;
    localparam logic [CODE_W-1:0] CODE_NO_ITALIC    = 16'd23;
    localparam logic [CODE_W-1:0] CODE_NO_UNDERLINE = 16'd24;
    localparam logic [CODE_W-1:0] CODE_NO_BLINK     = 16'd25;
    localparam logic [CODE_W-1:0] CODE_NO_REVERSE   = 16'd27;
    localparam logic [CODE_W-1:0] CODE_NO_INVISIBLE = 16'd28;
    localparam logic [CODE_W-1:0] CODE_NO_STRUCK    = 16'd29;
    localparam logic [CODE_W-1:0] CODE_FG_LO        = 16'd30;
    localparam logic [CODE_W-1:0] CODE_FG_HI        = 16'd37;
    localparam logic [CODE_W-1:0] CODE_FG_EXT       = 16'd38;
    localparam logic [CODE_W-1:0] CODE_FG_DEFAULT   = 16'd39;
    localparam logic [CODE_W-1:0] CODE_BG_LO        = 16'd40;
    localparam logic [CODE_W-1:0] CODE_BG_HI        = 16'd47;
    localparam logic [CODE_W-1:0] CODE_BG_EXT       = 16'd48;
    localparam logic [CODE_W-1:0] CODE_BG_DEFAULT   = 16'd49;
    localparam logic [CODE_W-1:0] CODE_UL_COLOUR    = 16'd58;
    localparam logic [CODE_W-1:0] CODE_UL_DEFAULT   = 16'd59;
    localparam logic [CODE_W-1:0] CODE_FG_BRIGHT_LO = 16'd90;
    localparam logic [CODE_W-1:0] CODE_FG_BRIGHT_HI = 16'd97;
    localparam logic [CODE_W-1:0] CODE_BG_BRIGHT_LO = 16'd100;
    localparam logic [CODE_W-1:0] CODE_BG_BRIGHT_HI = 16'd107;
    localparam logic [CODE_W-1:0] BRIGHT_OFFSET     = 16'd8;

    // Extended colour modes.
    localparam logic [CODE_W-1:0] MODE_RGB   = 16'd2;
    localparam logic [CODE_W-1:0] MODE_INDEX = 16'd5;

    // Configuration register indexes.
    localparam logic CFG_DEFAULT_FG = 1'b0;
    localparam logic CFG_DEFAULT_BG = 1'b1;

    localparam logic [COL_W-1:0]        RESET_FG = 25'd7;
    localparam logic [COL_W-1:0]        RESET_BG = 25'd0;
    localparam logic signed [SUB_W-1:0] UNSET    = -17'sd1;

    // One buffered parameter; code sits in the lowest bits.
    typedef struct packed {
        logic signed [SUB_W-1:0] sub_three;
        logic signed [SUB_W-1:0] sub_two;
        logic signed [SUB_W-1:0] sub_one;
        logic signed [SUB_W-1:0] sub_zero;
        logic [CODE_W-1:0]       code;
    } entry_t;

    // One result; style_flags sits in the lowest bits.
    typedef struct packed {
        logic signed [SUB_W-1:0] underline_blue;
        logic signed [SUB_W-1:0] underline_green;
        logic signed [SUB_W-1:0] underline_red;
        logic signed [SUB_W-1:0] underline_style;
        logic [COL_W-1:0]        background;
        logic [COL_W-1:0]        foreground;
        logic [FLAG_W-1:0]       style_flags;
    } result_t;

endpackage

[hdl/sgrap_param_buffer.sv]
// Parameter buffer: one write port and one registered read port.
`timescale 1ns / 1ps

module sgrap_param_buffer #(
    parameter int MAX_PARAMS = 16,
    parameter int AW         = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  sgrap_pkg::entry_t wr_data,
    input  logic [AW-1:0]    rd_addr,
    output sgrap_pkg::entry_t rd_data
);

    sgrap_pkg::entry_t mem [MAX_PARAMS];
    sgrap_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/sgrap_walker.sv]
// Sequencer that loads parameters and walks them to update the current attribute.
`timescale 1ns / 1ps

module sgrap_walker #(
    parameter int MAX_PARAMS = 16,
    parameter int AW         = 4,
    parameter int CW         = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sgrap_pkg::entry_t                   in_entry,
    input  logic                                in_last,
    output logic                                res_valid,
    input  logic                                res_ready,
    output sgrap_pkg::result_t                  res_data,
    input  logic [sgrap_pkg::COL_W-1:0]         dflt_fg,
    input  logic [sgrap_pkg::COL_W-1:0]         dflt_bg,
    output logic                                wr_en,
    output logic [AW-1:0]                       wr_addr,
    output sgrap_pkg::entry_t                   wr_data,
    output logic [AW-1:0]                       rd_addr,
    input  sgrap_pkg::entry_t                   rd_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_CODE  = 3'd2;
    localparam logic [2:0] S_MODE  = 3'd3;
    localparam logic [2:0] S_RGB   = 3'd4;
    localparam logic [2:0] S_IDX   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    part_reg, part_next;
    logic          ext_bg_reg, ext_bg_next;
    logic          over_reg, over_next;
    logic [23:0]   rgb_reg, rgb_next;

    logic [sgrap_pkg::FLAG_W-1:0]       flags_reg, flags_next;
    logic [sgrap_pkg::COL_W-1:0]        fg_reg, fg_next;
    logic [sgrap_pkg::COL_W-1:0]        bg_reg, bg_next;
    logic signed [sgrap_pkg::SUB_W-1:0] ust_reg, ust_next;
    logic signed [sgrap_pkg::SUB_W-1:0] ur_reg, ur_next;
    logic signed [sgrap_pkg::SUB_W-1:0] ug_reg, ug_next;
    logic signed [sgrap_pkg::SUB_W-1:0] ub_reg, ub_next;

    logic               out_valid_reg, out_valid_next;
    sgrap_pkg::result_t out_data_reg, out_data_next;

    logic          accept;
    logic [CW:0]   idx_ext;
    logic [CW:0]   count_ext;
    logic [CW-1:0] rd_idx;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign idx_ext   = {1'b0, idx_reg};
    assign count_ext = {1'b0, count_reg};

    assign in_ready  = (state_reg == S_IDLE);
    assign wr_en     = accept && (count_reg < CW'(MAX_PARAMS));
    assign wr_addr   = count_reg[AW-1:0];
    assign wr_data   = in_entry;
    assign rd_addr   = rd_idx[AW-1:0];
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    always_comb
    begin
        logic [sgrap_pkg::CODE_W-1:0] code;
        logic [sgrap_pkg::COL_W-1:0]  ext_colour;
        logic                         ext_ok;

        code           = rd_data.code;
        ext_colour     = '0;
        ext_ok         = 1'b0;
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        part_next      = part_reg;
        ext_bg_next    = ext_bg_reg;
        over_next      = over_reg;
        rgb_next       = rgb_reg;
        flags_next     = flags_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        ust_next       = ust_reg;
        ur_next        = ur_reg;
        ug_next        = ug_reg;
        ub_next        = ub_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !res_ready;
        rd_idx         = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (wr_en)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (in_last)
                    begin
                        idx_next   = '0;
                        state_next = S_ISSUE;
                    end
                end
            end

            S_ISSUE:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CODE;
                end
            end

            S_CODE:
            begin
                idx_next   = idx_reg + CW'(1);
                state_next = S_ISSUE;
                case (code) inside
                    sgrap_pkg::CODE_RESET:
                    begin
                        flags_next[sgrap_pkg::FLAG_STRUCK:sgrap_pkg::FLAG_BOLD] = '0;
                        fg_next  = dflt_fg;
                        bg_next  = dflt_bg;
                        ust_next = sgrap_pkg::UNSET;
                        ur_next  = sgrap_pkg::UNSET;
                        ug_next  = sgrap_pkg::UNSET;
                        ub_next  = sgrap_pkg::UNSET;
                    end
                    sgrap_pkg::CODE_BOLD:   flags_next[sgrap_pkg::FLAG_BOLD] = 1'b1;
                    sgrap_pkg::CODE_FAINT:  flags_next[sgrap_pkg::FLAG_FAINT] = 1'b1;
                    sgrap_pkg::CODE_ITALIC: flags_next[sgrap_pkg::FLAG_ITALIC] = 1'b1;
                    sgrap_pkg::CODE_UNDERLINE:
                    begin
                        ust_next = rd_data.sub_zero;
                        flags_next[sgrap_pkg::FLAG_UNDERLINE] = (rd_data.sub_zero != '0);
                        flags_next[sgrap_pkg::FLAG_DIRTY_UL] =
                            !flags_reg[sgrap_pkg::FLAG_DIRTY_UL];
                    end
                    sgrap_pkg::CODE_BLINK_SLOW, sgrap_pkg::CODE_BLINK_FAST:
                        flags_next[sgrap_pkg::FLAG_BLINK] = 1'b1;
                    sgrap_pkg::CODE_REVERSE:   flags_next[sgrap_pkg::FLAG_REVERSE] = 1'b1;
                    sgrap_pkg::CODE_INVISIBLE: flags_next[sgrap_pkg::FLAG_INVISIBLE] = 1'b1;
                    sgrap_pkg::CODE_STRUCK:    flags_next[sgrap_pkg::FLAG_STRUCK] = 1'b1;
                    sgrap_pkg::CODE_NO_BOLD:
                    begin
                        flags_next[sgrap_pkg::FLAG_BOLD]  = 1'b0;
                        flags_next[sgrap_pkg::FLAG_FAINT] = 1'b0;
                    end
                    sgrap_pkg::CODE_NO_ITALIC:    flags_next[sgrap_pkg::FLAG_ITALIC] = 1'b0;
                    sgrap_pkg::CODE_NO_UNDERLINE: flags_next[sgrap_pkg::FLAG_UNDERLINE] = 1'b0;
                    sgrap_pkg::CODE_NO_BLINK:     flags_next[sgrap_pkg::FLAG_BLINK] = 1'b0;
                    sgrap_pkg::CODE_NO_REVERSE:   flags_next[sgrap_pkg::FLAG_REVERSE] = 1'b0;
                    sgrap_pkg::CODE_NO_INVISIBLE: flags_next[sgrap_pkg::FLAG_INVISIBLE] = 1'b0;
                    sgrap_pkg::CODE_NO_STRUCK:    flags_next[sgrap_pkg::FLAG_STRUCK] = 1'b0;
                    sgrap_pkg::CODE_FG_EXT, sgrap_pkg::CODE_BG_EXT:
                    begin
                        ext_bg_next = (code == sgrap_pkg::CODE_BG_EXT);
                        // Look at the mode only if a parameter follows.
                        if (idx_ext + (CW+1)'(1) < count_ext)
                        begin
                            idx_next   = idx_reg;
                            rd_idx     = idx_reg + CW'(1);
                            state_next = S_MODE;
                        end
                    end
                    sgrap_pkg::CODE_FG_DEFAULT: fg_next = dflt_fg;
                    sgrap_pkg::CODE_BG_DEFAULT: bg_next = dflt_bg;
                    sgrap_pkg::CODE_UL_COLOUR:
                    begin
                        ur_next = rd_data.sub_one;
                        ug_next = rd_data.sub_two;
                        ub_next = rd_data.sub_three;
                        flags_next[sgrap_pkg::FLAG_DIRTY_UL] =
                            !flags_reg[sgrap_pkg::FLAG_DIRTY_UL];
                    end
                    sgrap_pkg::CODE_UL_DEFAULT:
                    begin
                        ur_next = sgrap_pkg::UNSET;
                        ug_next = sgrap_pkg::UNSET;
                        ub_next = sgrap_pkg::UNSET;
                        flags_next[sgrap_pkg::FLAG_DIRTY_UL] =
                            !flags_reg[sgrap_pkg::FLAG_DIRTY_UL];
                    end
                    [sgrap_pkg::CODE_FG_LO:sgrap_pkg::CODE_FG_HI]:
                        fg_next = sgrap_pkg::COL_W'(code - sgrap_pkg::CODE_FG_LO);
                    [sgrap_pkg::CODE_BG_LO:sgrap_pkg::CODE_BG_HI]:
                        bg_next = sgrap_pkg::COL_W'(code - sgrap_pkg::CODE_BG_LO);
                    [sgrap_pkg::CODE_FG_BRIGHT_LO:sgrap_pkg::CODE_FG_BRIGHT_HI]:
                        fg_next = sgrap_pkg::COL_W'(code - sgrap_pkg::CODE_FG_BRIGHT_LO
                                                    + sgrap_pkg::BRIGHT_OFFSET);
                    [sgrap_pkg::CODE_BG_BRIGHT_LO:sgrap_pkg::CODE_BG_BRIGHT_HI]:
                        bg_next = sgrap_pkg::COL_W'(code - sgrap_pkg::CODE_BG_BRIGHT_LO
                                                    + sgrap_pkg::BRIGHT_OFFSET);
                    default:
                    begin
                    end
                endcase
            end

            S_MODE:
            begin
                // A failed mode check consumes only the 38 or 48 itself.
                idx_next   = idx_reg + CW'(1);
                state_next = S_ISSUE;
                if (code == sgrap_pkg::MODE_RGB)
                begin
                    if (idx_ext + (CW+1)'(4) < count_ext)
                    begin
                        idx_next   = idx_reg;
                        rd_idx     = idx_reg + CW'(2);
                        part_next  = 2'd0;
                        over_next  = 1'b0;
                        state_next = S_RGB;
                    end
                end
                else if (code == sgrap_pkg::MODE_INDEX)
                begin
                    if (idx_ext + (CW+1)'(2) < count_ext)
                    begin
                        idx_next   = idx_reg;
                        rd_idx     = idx_reg + CW'(2);
                        state_next = S_IDX;
                    end
                end
            end

            S_RGB:
            begin
                rgb_next  = {rgb_reg[15:0], code[7:0]};
                over_next = over_reg || (|code[15:8]);
                if (part_reg != 2'd2)
                begin
                    rd_idx    = idx_reg + CW'(3) + CW'(part_reg);
                    part_next = part_reg + 2'd1;
                end
                else
                begin
                    ext_ok     = !over_next;
                    ext_colour = {1'b1, rgb_next};
                    idx_next   = idx_reg + CW'(5);
                    state_next = S_ISSUE;
                end
            end

            S_IDX:
            begin
                ext_ok     = !(|code[15:8]);
                ext_colour = sgrap_pkg::COL_W'(code[7:0]);
                idx_next   = idx_reg + CW'(3);
                state_next = S_ISSUE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.style_flags     = flags_reg;
                    out_data_next.foreground      = fg_reg;
                    out_data_next.background      = bg_reg;
                    out_data_next.underline_style = ust_reg;
                    out_data_next.underline_red   = ur_reg;
                    out_data_next.underline_green = ug_reg;
                    out_data_next.underline_blue  = ub_reg;
                    count_next                    = '0;
                    state_next                    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ext_ok)
        begin
            if (ext_bg_reg)
            begin
                bg_next = ext_colour;
            end
            else
            begin
                fg_next = ext_colour;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            part_reg      <= '0;
            ext_bg_reg    <= 1'b0;
            over_reg      <= 1'b0;
            flags_reg     <= '0;
            fg_reg        <= sgrap_pkg::RESET_FG;
            bg_reg        <= sgrap_pkg::RESET_BG;
            ust_reg       <= sgrap_pkg::UNSET;
            ur_reg        <= sgrap_pkg::UNSET;
            ug_reg        <= sgrap_pkg::UNSET;
            ub_reg        <= sgrap_pkg::UNSET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            part_reg      <= part_next;
            ext_bg_reg    <= ext_bg_next;
            over_reg      <= over_next;
            flags_reg     <= flags_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            ust_reg       <= ust_next;
            ur_reg        <= ur_next;
            ug_reg        <= ug_next;
            ub_reg        <= ub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg      <= rgb_next;
        out_data_reg <= out_data_next;
    end

endmodule

[hdl/sgr_attribute_processor_unit.sv]
// Top level of the SGR attribute processor: ports, default colour registers, checks.
//
//  Channel   Direction  Handshake          Carries
//  s_*       in         s_tvalid/s_tready  one SGR parameter per beat, tlast ends sequence
//  m_*       out        m_tvalid/m_tready  the updated attribute, one beat per sequence
//  cfg_*     in         cfg_we             default foreground / background colours
//
// A parameter beat is taken only while idle; rst_n restores the default attribute.
// A tlast beat starts a walk that issues and decodes each buffered code in turn; a 38 or
// 48 then checks its mode and reads three components for an RGB group, one index for an
// indexed group, or nothing if the mode fails. Last, the walk loads the output register.
// s_tready stays low for the whole walk. The next sequence may load while a result waits,
// but its walk holds at the end until the output register is free.
`timescale 1ns / 1ps

module sgr_attribute_processor_unit #(
    parameter int MAX_PARAMS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // code[15:0], sub_zero[32:16], sub_one[49:33], sub_two[66:50], sub_three[83:67], pad
    input  logic [87:0]  s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // style_flags[8:0], foreground[33:9], background[58:34], underline_style[75:59],
    // underline_red[92:76], underline_green[109:93], underline_blue[126:110], pad
    output logic [127:0] m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [24:0]  cfg_data
);

    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);

    logic [sgrap_pkg::COL_W-1:0] dflt_fg_reg;
    logic [sgrap_pkg::COL_W-1:0] dflt_bg_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    sgrap_pkg::entry_t  wr_data;
    logic [AW-1:0]      rd_addr;
    sgrap_pkg::entry_t  rd_data;
    sgrap_pkg::result_t res_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_fg_reg <= sgrap_pkg::RESET_FG;
            dflt_bg_reg <= sgrap_pkg::RESET_BG;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sgrap_pkg::CFG_DEFAULT_FG: dflt_fg_reg <= cfg_data;
                sgrap_pkg::CFG_DEFAULT_BG: dflt_bg_reg <= cfg_data;
                default:                   dflt_fg_reg <= dflt_fg_reg;
            endcase
        end
    end

    sgrap_param_buffer #(
        .MAX_PARAMS (MAX_PARAMS),
        .AW         (AW)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sgrap_walker #(
        .MAX_PARAMS (MAX_PARAMS),
        .AW         (AW),
        .CW         (CW)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_entry  (sgrap_pkg::entry_t'(s_tdata[83:0])),
        .in_last   (s_tlast),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res_data),
        .dflt_fg   (dflt_fg_reg),
        .dflt_bg   (dflt_bg_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    assign m_tdata = {1'b0, res_data};

    // The walk begins right after the closing beat, so the input side must close.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still ready after the closing parameter beat");

    // A new result only comes out of a walk, never while idle.
    a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a walk");

    // Ending a walk always leaves a result in the output register.
    a_walk_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) |-> m_tvalid)
        else $error("walk ended without a result");

endmodule

[bench/sgr_attribute_processor_unit_tb.sv]
// Self-checking testbench for the SGR attribute processor with a built-in attribute predictor.
`timescale 1ns / 1ps

module sgr_attribute_processor_unit_tb;

    localparam int MAX_PARAMS       = 16;
    localparam int COLOUR_MAX       = 255;
    localparam int EPOCHS           = 6;
    localparam int RANDOM_PER_EPOCH = 215;
    localparam int SETTLE_CYCLES    = 150;

    typedef struct packed {
        logic              last;
        sgrap_pkg::entry_t e;
    } param_beat_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata   = '0;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;
    logic         cfg_we    = 1'b0;
    logic         cfg_index = 1'b0;
    logic [24:0]  cfg_data  = '0;

    param_beat_t        pending_params[$];
    sgrap_pkg::entry_t  draft_seq[$];
    sgrap_pkg::result_t expected_attrs[$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   errors        = 0;
    logic beat_taken    = 1'b0;

    // Predicted state of the block.
    sgrap_pkg::entry_t                  held[MAX_PARAMS];
    int                                 held_count    = 0;
    logic [sgrap_pkg::COL_W-1:0]        dflt_fg       = sgrap_pkg::RESET_FG;
    logic [sgrap_pkg::COL_W-1:0]        dflt_bg       = sgrap_pkg::RESET_BG;
    logic [sgrap_pkg::FLAG_W-1:0]       attr_flags    = '0;
    logic [sgrap_pkg::COL_W-1:0]        attr_fg       = sgrap_pkg::RESET_FG;
    logic [sgrap_pkg::COL_W-1:0]        attr_bg       = sgrap_pkg::RESET_BG;
    logic signed [sgrap_pkg::SUB_W-1:0] attr_ul_style = sgrap_pkg::UNSET;
    logic signed [sgrap_pkg::SUB_W-1:0] attr_ul_red   = sgrap_pkg::UNSET;
    logic signed [sgrap_pkg::SUB_W-1:0] attr_ul_green = sgrap_pkg::UNSET;
    logic signed [sgrap_pkg::SUB_W-1:0] attr_ul_blue  = sgrap_pkg::UNSET;

    sgr_attribute_processor_unit #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Decodes 38/48 colour at pos; pos moves over what the colour consumed.
    function automatic bit ext_colour(inout int pos,
                                      output logic [sgrap_pkg::COL_W-1:0] col);
        int p;
        p = pos;
        col = '0;
        if (p + 1 >= held_count)
            return 1'b0;
        if (held[p + 1].code == sgrap_pkg::MODE_RGB)
        begin
            if (p + 4 >= held_count)
                return 1'b0;
            pos = p + 4;
            if (held[p + 2].code > COLOUR_MAX || held[p + 3].code > COLOUR_MAX
                || held[p + 4].code > COLOUR_MAX)
                return 1'b0;
            col = {1'b1, held[p + 2].code[7:0], held[p + 3].code[7:0], held[p + 4].code[7:0]};
            return 1'b1;
        end
        if (held[p + 1].code == sgrap_pkg::MODE_INDEX)
        begin
            if (p + 2 >= held_count)
                return 1'b0;
            pos = p + 2;
            if (held[p + 2].code > COLOUR_MAX)
                return 1'b0;
            col = sgrap_pkg::COL_W'(held[p + 2].code);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic walk_sequence();
        int                           i;
        logic [sgrap_pkg::CODE_W-1:0] c;
        logic [sgrap_pkg::COL_W-1:0]  col;
        for (i = 0; i < held_count; i++)
        begin
            c = held[i].code;
            case (c)
                sgrap_pkg::CODE_RESET:
                begin
                    attr_flags[sgrap_pkg::FLAG_STRUCK:sgrap_pkg::FLAG_BOLD] = '0;
                    attr_fg       = dflt_fg;
                    attr_bg       = dflt_bg;
                    attr_ul_style = sgrap_pkg::UNSET;
                    attr_ul_red   = sgrap_pkg::UNSET;
                    attr_ul_green = sgrap_pkg::UNSET;
                    attr_ul_blue  = sgrap_pkg::UNSET;
                end
                sgrap_pkg::CODE_BOLD:   attr_flags[sgrap_pkg::FLAG_BOLD] = 1'b1;
                sgrap_pkg::CODE_FAINT:  attr_flags[sgrap_pkg::FLAG_FAINT] = 1'b1;
                sgrap_pkg::CODE_ITALIC: attr_flags[sgrap_pkg::FLAG_ITALIC] = 1'b1;
                sgrap_pkg::CODE_UNDERLINE:
                begin
                    attr_ul_style = held[i].sub_zero;
                    attr_flags[sgrap_pkg::FLAG_UNDERLINE] = (held[i].sub_zero != 0);
                    attr_flags[sgrap_pkg::FLAG_DIRTY_UL] = ~attr_flags[sgrap_pkg::FLAG_DIRTY_UL];
                end
                sgrap_pkg::CODE_BLINK_SLOW,
                sgrap_pkg::CODE_BLINK_FAST:
                    attr_flags[sgrap_pkg::FLAG_BLINK] = 1'b1;
                sgrap_pkg::CODE_REVERSE:   attr_flags[sgrap_pkg::FLAG_REVERSE] = 1'b1;
                sgrap_pkg::CODE_INVISIBLE: attr_flags[sgrap_pkg::FLAG_INVISIBLE] = 1'b1;
                sgrap_pkg::CODE_STRUCK:    attr_flags[sgrap_pkg::FLAG_STRUCK] = 1'b1;
                sgrap_pkg::CODE_NO_BOLD:
                begin
                    attr_flags[sgrap_pkg::FLAG_BOLD]  = 1'b0;
                    attr_flags[sgrap_pkg::FLAG_FAINT] = 1'b0;
                end
                sgrap_pkg::CODE_NO_ITALIC:    attr_flags[sgrap_pkg::FLAG_ITALIC] = 1'b0;
                sgrap_pkg::CODE_NO_UNDERLINE: attr_flags[sgrap_pkg::FLAG_UNDERLINE] = 1'b0;
                sgrap_pkg::CODE_NO_BLINK:     attr_flags[sgrap_pkg::FLAG_BLINK] = 1'b0;
                sgrap_pkg::CODE_NO_REVERSE:   attr_flags[sgrap_pkg::FLAG_REVERSE] = 1'b0;
                sgrap_pkg::CODE_NO_INVISIBLE: attr_flags[sgrap_pkg::FLAG_INVISIBLE] = 1'b0;
                sgrap_pkg::CODE_NO_STRUCK:    attr_flags[sgrap_pkg::FLAG_STRUCK] = 1'b0;
                sgrap_pkg::CODE_FG_EXT:
                begin
                    if (ext_colour(i, col))
                        attr_fg = col;
                end
                sgrap_pkg::CODE_FG_DEFAULT:   attr_fg = dflt_fg;
                sgrap_pkg::CODE_BG_EXT:
                begin
                    if (ext_colour(i, col))
                        attr_bg = col;
                end
                sgrap_pkg::CODE_BG_DEFAULT:   attr_bg = dflt_bg;
                sgrap_pkg::CODE_UL_COLOUR:
                begin
                    attr_ul_red   = held[i].sub_one;
                    attr_ul_green = held[i].sub_two;
                    attr_ul_blue  = held[i].sub_three;
                    attr_flags[sgrap_pkg::FLAG_DIRTY_UL] = ~attr_flags[sgrap_pkg::FLAG_DIRTY_UL];
                end
                sgrap_pkg::CODE_UL_DEFAULT:
                begin
                    attr_ul_red   = sgrap_pkg::UNSET;
                    attr_ul_green = sgrap_pkg::UNSET;
                    attr_ul_blue  = sgrap_pkg::UNSET;
                    attr_flags[sgrap_pkg::FLAG_DIRTY_UL] = ~attr_flags[sgrap_pkg::FLAG_DIRTY_UL];
                end
                default:
                begin
                    if (c >= sgrap_pkg::CODE_FG_LO && c <= sgrap_pkg::CODE_FG_HI)
                        attr_fg = sgrap_pkg::COL_W'(c - sgrap_pkg::CODE_FG_LO);
                    else if (c >= sgrap_pkg::CODE_BG_LO && c <= sgrap_pkg::CODE_BG_HI)
                        attr_bg = sgrap_pkg::COL_W'(c - sgrap_pkg::CODE_BG_LO);
                    else if (c >= sgrap_pkg::CODE_FG_BRIGHT_LO
                             && c <= sgrap_pkg::CODE_FG_BRIGHT_HI)
                        attr_fg = sgrap_pkg::COL_W'(c - sgrap_pkg::CODE_FG_BRIGHT_LO
                                                    + sgrap_pkg::BRIGHT_OFFSET);
                    else if (c >= sgrap_pkg::CODE_BG_BRIGHT_LO
                             && c <= sgrap_pkg::CODE_BG_BRIGHT_HI)
                        attr_bg = sgrap_pkg::COL_W'(c - sgrap_pkg::CODE_BG_BRIGHT_LO
                                                    + sgrap_pkg::BRIGHT_OFFSET);
                end
            endcase
        end
    endtask

    // Buffers one accepted parameter; the last one of a sequence yields the new attribute.
    task automatic take_param(input sgrap_pkg::entry_t e, input logic last);
        sgrap_pkg::result_t r;
        if (held_count < MAX_PARAMS)
        begin
            held[held_count] = e;
            held_count++;
        end
        if (last)
        begin
            walk_sequence();
            held_count = 0;
            r.style_flags     = attr_flags;
            r.foreground      = attr_fg;
            r.background      = attr_bg;
            r.underline_style = attr_ul_style;
            r.underline_red   = attr_ul_red;
            r.underline_green = attr_ul_green;
            r.underline_blue  = attr_ul_blue;
            expected_attrs.insert(expected_attrs.size(), r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Parameter driver: a beat is held until taken, then the next one may follow.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || beat_taken)
            begin
                if (pending_params.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, pending_params[0].e};
                    s_tlast  <= pending_params[0].last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor for both sides; results are checked before a new sequence is predicted.
    always @(posedge clk)
    begin
        sgrap_pkg::result_t got;
        sgrap_pkg::result_t want;
        beat_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(sgrap_pkg::result_t)-1:0];
                if (expected_attrs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected attribute beat, expected none, actual %h",
                             $time, got);
                end
                else
                begin
                    want = expected_attrs.pop_front();
                    check_field("style_flags", want.style_flags, got.style_flags);
                    check_field("foreground", want.foreground, got.foreground);
                    check_field("background", want.background, got.background);
                    check_field("underline_style", want.underline_style, got.underline_style);
                    check_field("underline_red", want.underline_red, got.underline_red);
                    check_field("underline_green", want.underline_green, got.underline_green);
                    check_field("underline_blue", want.underline_blue, got.underline_blue);
                end
            end
            if (s_tvalid && s_tready)
            begin
                take_param(sgrap_pkg::entry_t'(s_tdata[$bits(sgrap_pkg::entry_t)-1:0]),
                           s_tlast);
                void'(pending_params.pop_front());
            end
        end
    end

    function automatic logic signed [sgrap_pkg::SUB_W-1:0] pick_sub();
        case ($urandom_range(0, 7))
            0:       return sgrap_pkg::UNSET;
            1:       return 17'sd0;
            2:       return 17'sd65535;
            default: return sgrap_pkg::SUB_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [sgrap_pkg::CODE_W-1:0] pick_component();
        case ($urandom_range(0, 19))
            0:       return sgrap_pkg::CODE_W'(COLOUR_MAX);
            1:       return '0;
            2:       return sgrap_pkg::CODE_W'($urandom_range(COLOUR_MAX + 1, 65535));
            default: return sgrap_pkg::CODE_W'($urandom_range(0, COLOUR_MAX));
        endcase
    endfunction

    task automatic add_param(input logic [sgrap_pkg::CODE_W-1:0] code,
                             input logic signed [sgrap_pkg::SUB_W-1:0] s0,
                             input logic signed [sgrap_pkg::SUB_W-1:0] s1,
                             input logic signed [sgrap_pkg::SUB_W-1:0] s2,
                             input logic signed [sgrap_pkg::SUB_W-1:0] s3);
        sgrap_pkg::entry_t e;
        e.code      = code;
        e.sub_zero  = s0;
        e.sub_one   = s1;
        e.sub_two   = s2;
        e.sub_three = s3;
        draft_seq.insert(draft_seq.size(), e);
    endtask

    task automatic add_code(input logic [sgrap_pkg::CODE_W-1:0] code);
        add_param(code, pick_sub(), pick_sub(), pick_sub(), pick_sub());
    endtask

    task automatic close_sequence();
        int          j;
        param_beat_t b;
        for (j = 0; j < draft_seq.size(); j++)
        begin
            b.last = (j == draft_seq.size() - 1);
            b.e    = draft_seq[j];
            pending_params.insert(pending_params.size(), b);
        end
        draft_seq.delete();
    endtask

    // Mostly well-formed colours, with unknown modes and cut-short groups mixed in.
    task automatic add_ext_colour();
        add_code($urandom_range(0, 1) ? sgrap_pkg::CODE_FG_EXT : sgrap_pkg::CODE_BG_EXT);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                add_code(sgrap_pkg::MODE_RGB);
                add_code(pick_component());
                add_code(pick_component());
                add_code(pick_component());
            end
            4, 5, 6:
            begin
                add_code(sgrap_pkg::MODE_INDEX);
                add_code(pick_component());
            end
            7:       add_code(sgrap_pkg::CODE_W'($urandom_range(0, 9)));
            8:
            begin
                add_code(sgrap_pkg::MODE_RGB);
                add_code(pick_component());
            end
            default: ;
        endcase
    endtask

    task automatic queue_directed();
        add_code(sgrap_pkg::CODE_BOLD);
        add_code(sgrap_pkg::CODE_FAINT);
        add_code(sgrap_pkg::CODE_ITALIC);
        add_code(sgrap_pkg::CODE_BLINK_FAST);
        add_code(sgrap_pkg::CODE_REVERSE);
        add_code(sgrap_pkg::CODE_STRUCK);
        add_param(sgrap_pkg::CODE_UNDERLINE, sgrap_pkg::UNSET, 17'sd0, 17'sd0, 17'sd0);
        add_param(sgrap_pkg::CODE_UL_COLOUR, 17'sd0, 17'sd65535, 17'sd0, sgrap_pkg::UNSET);
        close_sequence();
        add_code(sgrap_pkg::CODE_NO_BOLD);
        add_code(sgrap_pkg::CODE_NO_UNDERLINE);
        add_code(sgrap_pkg::CODE_NO_STRUCK);
        add_code(sgrap_pkg::CODE_UL_DEFAULT);
        close_sequence();
        // Truecolor foreground at the component extremes, then an indexed background.
        add_code(sgrap_pkg::CODE_FG_EXT);
        add_code(sgrap_pkg::MODE_RGB);
        add_code(sgrap_pkg::CODE_W'(COLOUR_MAX));
        add_code('0);
        add_code(sgrap_pkg::CODE_W'(COLOUR_MAX));
        add_code(sgrap_pkg::CODE_BG_EXT);
        add_code(sgrap_pkg::MODE_INDEX);
        add_code('0);
        close_sequence();
        // Index out of range, then an unknown mode whose codes stand on their own.
        add_code(sgrap_pkg::CODE_FG_EXT);
        add_code(sgrap_pkg::MODE_INDEX);
        add_code(sgrap_pkg::CODE_W'(COLOUR_MAX + 1));
        add_code(sgrap_pkg::CODE_BG_EXT);
        add_code(sgrap_pkg::CODE_REVERSE);
        add_code(sgrap_pkg::CODE_FG_BRIGHT_HI);
        close_sequence();
        add_code(16'hFFFF);
        add_code(sgrap_pkg::CODE_BG_BRIGHT_HI);
        add_param(sgrap_pkg::CODE_UNDERLINE, 17'sd0, sgrap_pkg::UNSET, sgrap_pkg::UNSET,
                  sgrap_pkg::UNSET);
        close_sequence();
        add_code(sgrap_pkg::CODE_RESET);
        close_sequence();
        // Extended background with no mode after it.
        add_code(sgrap_pkg::CODE_BG_EXT);
        close_sequence();
    endtask

    task automatic queue_random(input int budget);
        int count;
        int units;
        int k;
        count = 0;
        while (count < budget)
        begin
            units = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
            for (k = 0; k < units; k++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6:
                        add_code(sgrap_pkg::CODE_W'($urandom_range(0, 110)));
                    7, 8:                add_code(sgrap_pkg::CODE_UNDERLINE);
                    9, 10:               add_code(sgrap_pkg::CODE_UL_COLOUR);
                    11, 12, 13, 14, 15:  add_ext_colour();
                    16:                  add_code(sgrap_pkg::CODE_W'($urandom));
                    17:                  add_code(sgrap_pkg::CODE_RESET);
                    default:             add_code(sgrap_pkg::CODE_W'($urandom_range(1, 9)));
                endcase
            end
            count += draft_seq.size();
            close_sequence();
        end
    endtask

    // The sender holds off until every predicted attribute has been seen.
    task automatic wait_idle();
        while (pending_params.size() != 0 || s_tvalid || expected_attrs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_default(input logic idx, input logic [sgrap_pkg::COL_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == sgrap_pkg::CFG_DEFAULT_FG)
            dflt_fg = val;
        else
            dflt_bg = val;
    endtask

    initial
    begin
        int                          epoch;
        logic [sgrap_pkg::COL_W-1:0] fg_val;
        logic [sgrap_pkg::COL_W-1:0] bg_val;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (epoch = 0; epoch < EPOCHS; epoch++)
        begin
            wait_idle();
            case (epoch)
                0:
                begin
                    fg_val = '1;
                    bg_val = '0;
                end
                1:
                begin
                    fg_val = '0;
                    bg_val = '1;
                end
                2:
                begin
                    fg_val = sgrap_pkg::COL_W'($urandom);
                    bg_val = sgrap_pkg::COL_W'($urandom);
                end
                3:
                begin
                    fg_val = sgrap_pkg::RESET_FG;
                    bg_val = sgrap_pkg::RESET_BG;
                end
                4:
                begin
                    fg_val = {1'b1, 24'($urandom)};
                    bg_val = sgrap_pkg::COL_W'($urandom_range(0, COLOUR_MAX));
                end
                default:
                begin
                    fg_val = '1;
                    bg_val = '1;
                end
            endcase
            write_default(sgrap_pkg::CFG_DEFAULT_FG, fg_val);
            write_default(sgrap_pkg::CFG_DEFAULT_BG, bg_val);
            send_idle_pct = (epoch < 2) ? 14 : (epoch < 4) ? 58 : 0;
            recv_idle_pct = (epoch < 2) ? 58 : (epoch < 4) ? 14 : 0;
            if (epoch == 0)
                queue_directed();
            queue_random(RANDOM_PER_EPOCH);
        end
        wait_idle();
        if (errors == 0 && expected_attrs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
